// ----- hdl/cfp_pkg.sv -----
// ----------------------------------------------------------------------------
// cfp_pkg
// Shared types and constants of the command frame parser.
// ----------------------------------------------------------------------------
package cfp_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned KIND_W     = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned OUT_DATA_W = 48;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_BYTE    = 3'd0,
        REG_CODE_REQ_CMDS = 3'd1,
        REG_CODE_REQ_PER  = 3'd2,
        REG_CODE_SEND     = 3'd3,
        REG_CODE_REQ_RC   = 3'd4
    } cfg_reg_t;

    // Reset values of the configuration registers
    localparam logic [BYTE_W-1:0] RST_FRAME_BYTE    = 8'd126;
    localparam logic [BYTE_W-1:0] RST_CODE_REQ_CMDS = 8'd1;
    localparam logic [BYTE_W-1:0] RST_CODE_REQ_PER  = 8'd2;
    localparam logic [BYTE_W-1:0] RST_CODE_SEND     = 8'd3;
    localparam logic [BYTE_W-1:0] RST_CODE_REQ_RC   = 8'd4;

    // Frame type value held while no type has been taken
    localparam logic [BYTE_W-1:0] NO_FRAME_TYPE     = 8'd255;

    // Parser phases
    typedef enum logic [3:0] {
        PH_SYNC     = 4'd0,
        PH_TYPE     = 4'd1,
        PH_HDR_END  = 4'd2,
        PH_MODE     = 4'd3,
        PH_THROTTLE = 4'd4,
        PH_ROLL     = 4'd5,
        PH_PITCH    = 4'd6,
        PH_YAW      = 4'd7,
        PH_CLOSE    = 4'd8
    } phase_t;

    // Event kinds
    typedef enum logic [KIND_W-1:0] {
        EV_NEW_CMDS = 2'd0,
        EV_REQ_CMDS = 2'd1,
        EV_REQ_PER  = 2'd2,
        EV_REQ_RC   = 2'd3
    } ev_kind_t;

    // Configuration register set
    typedef struct packed {
        logic [BYTE_W-1:0] frame_byte;
        logic [BYTE_W-1:0] code_req_cmds;
        logic [BYTE_W-1:0] code_req_per;
        logic [BYTE_W-1:0] code_send;
        logic [BYTE_W-1:0] code_req_rc;
    } cfp_cfg_t;

    // One result item, packed yaw..kind so kind sits in the lowest bits
    typedef struct packed {
        logic signed [BYTE_W-1:0] yaw_cmd;
        logic signed [BYTE_W-1:0] pitch_cmd;
        logic signed [BYTE_W-1:0] roll_cmd;
        logic signed [BYTE_W-1:0] throttle_cmd;
        logic        [BYTE_W-1:0] flight_mode;
        ev_kind_t                 event_kind;
    } cfp_result_t;

    localparam int unsigned RESULT_W = $bits(cfp_result_t);

endpackage

// ----- hdl/cfp_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// cfp_cfg_regs
// Configuration register file: frame byte and the four type codes.
// ----------------------------------------------------------------------------
module cfp_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [cfp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cfp_pkg::BYTE_W-1:0]      cfg_data,
    output cfp_pkg::cfp_cfg_t               cfg
);
    import cfp_pkg::*;

    cfp_cfg_t cfg_reg;
    cfp_cfg_t cfg_next;

    // Decode the register index; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_BYTE:    cfg_next.frame_byte    = cfg_data;
                REG_CODE_REQ_CMDS: cfg_next.code_req_cmds = cfg_data;
                REG_CODE_REQ_PER:  cfg_next.code_req_per  = cfg_data;
                REG_CODE_SEND:     cfg_next.code_send     = cfg_data;
                REG_CODE_REQ_RC:   cfg_next.code_req_rc   = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_byte    <= RST_FRAME_BYTE;
            cfg_reg.code_req_cmds <= RST_CODE_REQ_CMDS;
            cfg_reg.code_req_per  <= RST_CODE_REQ_PER;
            cfg_reg.code_send     <= RST_CODE_SEND;
            cfg_reg.code_req_rc   <= RST_CODE_REQ_RC;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hdl/cfp_parser.sv -----
// ----------------------------------------------------------------------------
// cfp_parser
// Input byte register and the frame state machine that turns bytes into events.
// ----------------------------------------------------------------------------
module cfp_parser (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_take,
    input  logic [cfp_pkg::BYTE_W-1:0]  in_byte,
    input  cfp_pkg::cfp_cfg_t           cfg,
    output logic                        pending,
    output logic                        res_valid,
    output cfp_pkg::cfp_result_t        res
);
    import cfp_pkg::*;

    logic              byte_valid_reg;
    logic [BYTE_W-1:0] byte_reg;

    phase_t            phase_reg;
    phase_t            phase_next;
    logic [BYTE_W-1:0] frame_type_reg;
    logic [BYTE_W-1:0] frame_type_next;
    logic [BYTE_W-1:0] mode_reg;
    logic [BYTE_W-1:0] mode_next;
    logic [BYTE_W-1:0] throttle_reg;
    logic [BYTE_W-1:0] throttle_next;
    logic [BYTE_W-1:0] roll_reg;
    logic [BYTE_W-1:0] roll_next;
    logic [BYTE_W-1:0] pitch_reg;
    logic [BYTE_W-1:0] pitch_next;
    logic [BYTE_W-1:0] yaw_reg;
    logic [BYTE_W-1:0] yaw_next;

    logic is_frame;
    logic is_type;

    // Input register: one byte per transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
        end
        else
        begin
            byte_valid_reg <= in_take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            byte_reg <= in_byte;
        end
    end

    assign pending = byte_valid_reg;

    assign is_frame = (byte_reg == cfg.frame_byte);
    assign is_type  = (byte_reg == cfg.code_req_cmds) || (byte_reg == cfg.code_req_per) ||
                      (byte_reg == cfg.code_send)     || (byte_reg == cfg.code_req_rc);

    // Next phase and held values
    always_comb
    begin
        phase_next      = phase_reg;
        frame_type_next = frame_type_reg;
        mode_next       = mode_reg;
        throttle_next   = throttle_reg;
        roll_next       = roll_reg;
        pitch_next      = pitch_reg;
        yaw_next        = yaw_reg;
        if (byte_valid_reg)
        begin
            unique case (phase_reg)
                PH_TYPE:
                begin
                    if (is_type)
                    begin
                        frame_type_next = byte_reg;
                        phase_next      = PH_HDR_END;
                    end
                    else
                    begin
                        phase_next = PH_SYNC;
                    end
                end
                PH_HDR_END:
                begin
                    // Send-commands header goes on to the payload; first match wins
                    if (is_frame && frame_type_reg != cfg.code_req_cmds &&
                        frame_type_reg != cfg.code_req_per &&
                        frame_type_reg == cfg.code_send)
                    begin
                        phase_next = PH_MODE;
                    end
                    else
                    begin
                        phase_next = PH_SYNC;
                    end
                end
                PH_MODE:
                begin
                    mode_next  = byte_reg;
                    phase_next = PH_THROTTLE;
                end
                PH_THROTTLE:
                begin
                    throttle_next = byte_reg;
                    phase_next    = PH_ROLL;
                end
                PH_ROLL:
                begin
                    roll_next  = byte_reg;
                    phase_next = PH_PITCH;
                end
                PH_PITCH:
                begin
                    pitch_next = byte_reg;
                    phase_next = PH_YAW;
                end
                PH_YAW:
                begin
                    yaw_next   = byte_reg;
                    phase_next = PH_CLOSE;
                end
                PH_CLOSE:
                begin
                    phase_next = PH_SYNC;
                end
                default:
                begin
                    // Sync, and any unused code behaves as sync
                    frame_type_next = NO_FRAME_TYPE;
                    phase_next      = is_frame ? PH_TYPE : PH_SYNC;
                end
            endcase
        end
    end

    // Event output
    always_comb
    begin
        res_valid        = 1'b0;
        res.event_kind   = EV_NEW_CMDS;
        res.flight_mode  = '0;
        res.throttle_cmd = '0;
        res.roll_cmd     = '0;
        res.pitch_cmd    = '0;
        res.yaw_cmd      = '0;
        if (byte_valid_reg)
        begin
            unique case (phase_reg)
                PH_HDR_END:
                begin
                    if (is_frame)
                    begin
                        if (frame_type_reg == cfg.code_req_cmds)
                        begin
                            res_valid      = 1'b1;
                            res.event_kind = EV_REQ_CMDS;
                        end
                        else if (frame_type_reg == cfg.code_req_per)
                        begin
                            res_valid      = 1'b1;
                            res.event_kind = EV_REQ_PER;
                        end
                        else if (frame_type_reg == cfg.code_send)
                        begin
                            res_valid = 1'b0;
                        end
                        else if (frame_type_reg == cfg.code_req_rc)
                        begin
                            res_valid      = 1'b1;
                            res.event_kind = EV_REQ_RC;
                        end
                    end
                end
                PH_CLOSE:
                begin
                    if (is_frame)
                    begin
                        res_valid        = 1'b1;
                        res.event_kind   = EV_NEW_CMDS;
                        res.flight_mode  = mode_reg;
                        res.throttle_cmd = throttle_reg;
                        res.roll_cmd     = roll_reg;
                        res.pitch_cmd    = pitch_reg;
                        res.yaw_cmd      = yaw_reg;
                    end
                end
                default:
                begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SYNC;
            frame_type_reg <= NO_FRAME_TYPE;
            mode_reg       <= '0;
            throttle_reg   <= '0;
            roll_reg       <= '0;
            pitch_reg      <= '0;
            yaw_reg        <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            frame_type_reg <= frame_type_next;
            mode_reg       <= mode_next;
            throttle_reg   <= throttle_next;
            roll_reg       <= roll_next;
            pitch_reg      <= pitch_next;
            yaw_reg        <= yaw_next;
        end
    end

endmodule

// ----- hdl/cfp_out_buffer.sv -----
// ----------------------------------------------------------------------------
// cfp_out_buffer
// Result register plus skid entry; grants input transfers against free room.
// ----------------------------------------------------------------------------
module cfp_out_buffer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  cfp_pkg::cfp_result_t                push_data,
    input  logic                                pending,
    output logic                                in_ready,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [cfp_pkg::OUT_DATA_W-1:0]      m_tdata
);
    import cfp_pkg::*;

    logic        out_valid_reg;
    cfp_result_t out_reg;
    logic        skid_valid_reg;
    cfp_result_t skid_reg;
    logic        pop;
    logic [1:0]  held_cnt;

    assign pop = out_valid_reg && m_tready;

    // Room for the byte in the input register and one more after this cycle
    assign held_cnt = {1'b0, out_valid_reg} + {1'b0, skid_valid_reg} + {1'b0, pending}
                      - {1'b0, pop};
    assign in_ready = (held_cnt < 2'd2);

    // Control: output entry refills from skid first, then from the parser
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= push;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
                if (push)
                begin
                    skid_reg <= push_data;
                end
            end
            else if (push)
            begin
                out_reg <= push_data;
            end
        end
        else if (push)
        begin
            skid_reg <= push_data;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - RESULT_W){1'b0}}, out_reg};

endmodule

// ----- hdl/command_frame_parser.sv -----
// ----------------------------------------------------------------------------
// command_frame_parser
// Recognizes command and request frames in a received serial byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (s_*) carries one received byte per transfer. Frames are
//   frame byte, type byte, frame byte; a send-commands header is followed by
//   mode, throttle, roll, pitch and yaw bytes and a closing frame byte.
//   Master stream (m_*) carries one event per recognized frame: request
//   commands, request periodic, request rc, or new commands with the five
//   payload values. Bytes that complete no frame give no transfer.
//   The cfg_* port writes the frame byte and the four type codes; write it
//   only while no bytes are in flight.
// Timing:
//   One byte per cycle sustained while m_tready takes the events. The byte
//   that closes a frame is held in the input byte register; its event is
//   then registered in the result register, after the skid entry if the output stalls, and leaves on m_tdata.
// Reset:
//   rst_n clears the parser to sync, empties the output, and loads the
//   default codes (frame 126, types 1, 2, 3, 4).
// Stall:
//   A skid entry behind the result register absorbs the byte in flight;
//   s_tready is low while held events plus the input byte, less one leaving, reach two.
// ----------------------------------------------------------------------------
module command_frame_parser (
    input  logic                                clk,
    input  logic                                rst_n,
    // tdata: rx_byte[7:0]
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [cfp_pkg::BYTE_W-1:0]          s_tdata,
    // tdata: event_kind[1:0], flight_mode[9:2], throttle_cmd[17:10],
    //        roll_cmd[25:18], pitch_cmd[33:26], yaw_cmd[41:34], zero[47:42]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [cfp_pkg::OUT_DATA_W-1:0]      m_tdata,
    input  logic                                cfg_we,
    input  logic [cfp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cfp_pkg::BYTE_W-1:0]          cfg_data
);
    import cfp_pkg::*;

    cfp_cfg_t    cfg;
    cfp_result_t res;
    logic        res_valid;
    logic        pending;
    logic        in_take;

    assign in_take = s_tvalid && s_tready;

    cfp_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cfp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_take   (in_take),
        .in_byte   (s_tdata),
        .cfg       (cfg),
        .pending   (pending),
        .res_valid (res_valid),
        .res       (res)
    );

    cfp_out_buffer u_out_buffer (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .pending   (pending),
        .in_ready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
